>>> hw/rtl/sgpe_pkg.sv
package sgpe_pkg;

    // configuration register indexes
    localparam logic [1:0] REG_BACKGROUND = 2'd0;
    localparam logic [1:0] REG_FOREGROUND = 2'd1;
    localparam logic [1:0] REG_SCALE      = 2'd2;

    // input item opcodes
    localparam logic FUNC_LOAD = 1'b0;
    localparam logic FUNC_DRAW = 1'b1;

    // command queue between front and back
    localparam int QDEPTH = 2;
    localparam int QPTR_W = $clog2(QDEPTH);

    // one classified item as it sits in the command queue
    typedef struct packed {
        logic        draw;
        logic        hit;     // code maps to a glyph slot within the store range
        logic [7:0]  glyph;
        logic [2:0]  row;
        logic [7:0]  data;
        logic [15:0] ox;
        logic [15:0] oy;
    } cmd_t;

    typedef struct packed {
        logic [15:0] background;
        logic [15:0] foreground;
        logic [4:0]  scale;
    } cfg_t;

    typedef struct packed {
        logic busy;
        logic ram_we;
    } back_stat_t;

endpackage

>>> hw/rtl/sgpe_ram.sv
module sgpe_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 768
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> hw/rtl/sgpe_front.sv
module sgpe_front #(
    parameter int GLYPH_COUNT = 96,
    parameter int FIRST_CODE  = 32
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    output logic          full,
    input  logic          func,
    input  logic [7:0]    char_code,
    input  logic [2:0]    glyph_row,
    input  logic [7:0]    glyph_byte,
    input  logic [15:0]   origin_x,
    input  logic [15:0]   origin_y,
    output logic          cmd_valid,
    output sgpe_pkg::cmd_t cmd,
    input  logic          cmd_pop
);

    import sgpe_pkg::*;

    localparam logic [7:0] FirstCode  = 8'(FIRST_CODE);
    localparam logic [8:0] GlyphLimit = 9'(GLYPH_COUNT);

    cmd_t                q_reg [QDEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg;
    logic [QPTR_W-1:0]   rd_ptr_reg;
    logic [QPTR_W:0]     count_reg;
    logic [QPTR_W:0]     count_next;
    logic                enq;
    logic                deq;
    logic [7:0]          glyph;
    cmd_t                cmd_in;

    // glyph slot wraps modulo 256 before the range check
    assign glyph = char_code - FirstCode;

    always_comb
    begin
        cmd_in.draw  = (func == FUNC_DRAW);
        cmd_in.hit   = ({1'b0, glyph} < GlyphLimit);
        cmd_in.glyph = glyph;
        cmd_in.row   = glyph_row;
        cmd_in.data  = glyph_byte;
        cmd_in.ox    = origin_x;
        cmd_in.oy    = origin_y;
    end

    assign full      = (count_reg == (QPTR_W+1)'(QDEPTH));
    assign cmd_valid = (count_reg != '0);
    assign cmd       = q_reg[rd_ptr_reg];
    assign enq       = push && !full;
    assign deq       = cmd_pop && cmd_valid;

    always_comb
    begin
        count_next = count_reg;
        if (enq && !deq)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (deq && !enq)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (enq)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (deq)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (enq)
        begin
            q_reg[wr_ptr_reg] <= cmd_in;
        end
    end

endmodule

>>> hw/rtl/sgpe_back.sv
module sgpe_back #(
    parameter int ADDR_W = 10
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cmd_valid,
    input  sgpe_pkg::cmd_t         cmd,
    output logic                   cmd_pop,
    input  sgpe_pkg::cfg_t         cfg,
    output logic                   ram_we,
    output logic [ADDR_W-1:0]      ram_waddr,
    output logic [7:0]             ram_wdata,
    output logic                   ram_re,
    output logic [ADDR_W-1:0]      ram_raddr,
    input  logic [7:0]             ram_rdata,
    output sgpe_pkg::back_stat_t   stat,
    output logic                   empty,
    input  logic                   pop,
    output logic [15:0]            fill_x,
    output logic [15:0]            fill_y,
    output logic [4:0]             fill_size,
    output logic [15:0]            fill_color,
    output logic                   last_dot
);

    import sgpe_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_LOAD = 2'd1;
    localparam logic [1:0] S_RUN  = 2'd2;

    logic [1:0]  state_reg;
    logic [1:0]  state_next;
    logic [7:0]  glyph_reg;
    logic        hit_reg;
    logic [15:0] oy_reg;
    logic [15:0] x_reg;
    logic [15:0] y_reg;
    logic [5:0]  n_reg;
    logic [7:0]  bits_reg;

    logic        out_valid_reg;
    logic [15:0] out_x_reg;
    logic [15:0] out_y_reg;
    logic [4:0]  out_size_reg;
    logic [15:0] out_color_reg;
    logic        out_last_reg;

    logic        advance;
    logic        emit;
    logic [2:0]  col;
    logic [2:0]  dot;
    logic [15:0] step;
    logic [7:0]  fetched;
    logic [10:0] waddr_full;
    logic [10:0] raddr_full;
    logic [2:0]  rd_byte;

    assign col     = n_reg[5:3];
    assign dot     = n_reg[2:0];
    assign step    = {11'd0, cfg.scale};
    assign advance = !out_valid_reg || pop;
    assign emit    = (state_reg == S_RUN) && advance;
    assign fetched = hit_reg ? ram_rdata : 8'd0;

    assign cmd_pop    = (state_reg == S_IDLE) && cmd_valid;
    assign ram_we     = cmd_pop && !cmd.draw && cmd.hit;
    assign waddr_full = {cmd.glyph, cmd.row};
    assign ram_waddr  = waddr_full[ADDR_W-1:0];
    assign ram_wdata  = cmd.data;

    // byte 7 at start, byte 6 while loading, then two columns ahead
    always_comb
    begin
        ram_re     = 1'b0;
        rd_byte    = 3'd7;
        raddr_full = {cmd.glyph, 3'd7};
        case (state_reg)
            S_IDLE:
            begin
                ram_re = cmd_pop && cmd.draw;
            end
            S_LOAD:
            begin
                ram_re     = 1'b1;
                rd_byte    = 3'd6;
                raddr_full = {glyph_reg, rd_byte};
            end
            S_RUN:
            begin
                ram_re     = emit && (dot == 3'd7) && (col <= 3'd5);
                rd_byte    = 3'd5 - col;
                raddr_full = {glyph_reg, rd_byte};
            end
            default:
            begin
                ram_re = 1'b0;
            end
        endcase
    end
    assign ram_raddr = raddr_full[ADDR_W-1:0];

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (cmd_pop && cmd.draw)
                begin
                    state_next = S_LOAD;
                end
            end
            S_LOAD:
            begin
                state_next = S_RUN;
            end
            S_RUN:
            begin
                if (emit && (n_reg == 6'd63))
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (pop)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_pop && cmd.draw)
        begin
            glyph_reg <= cmd.glyph;
            hit_reg   <= cmd.hit;
            oy_reg    <= cmd.oy;
            x_reg     <= cmd.ox;
            y_reg     <= cmd.oy;
            n_reg     <= 6'd0;
        end
        if (state_reg == S_LOAD)
        begin
            bits_reg <= fetched;
        end
        if (emit)
        begin
            out_x_reg     <= x_reg;
            out_y_reg     <= y_reg;
            out_size_reg  <= cfg.scale;
            out_color_reg <= bits_reg[7] ? cfg.foreground : cfg.background;
            out_last_reg  <= (n_reg == 6'd63);
            n_reg         <= n_reg + 1'b1;
            if (dot == 3'd7)
            begin
                x_reg    <= x_reg + step;
                y_reg    <= oy_reg;
                bits_reg <= fetched;
            end
            else
            begin
                y_reg    <= y_reg - step;
                bits_reg <= {bits_reg[6:0], 1'b0};
            end
        end
    end

    assign empty      = !out_valid_reg;
    assign fill_x     = out_x_reg;
    assign fill_y     = out_y_reg;
    assign fill_size  = out_size_reg;
    assign fill_color = out_color_reg;
    assign last_dot   = out_last_reg;

    assign stat.busy   = (state_reg != S_IDLE);
    assign stat.ram_we = ram_we;

endmodule

>>> hw/rtl/scaled_glyph_pixel_expander.sv
// Scaled 8x8 glyph renderer. Load items (func 0) write one byte of the glyph store
// when the code is in range; draw items (func 1) expand one character into 64
// fill-square beats, column by column from glyph byte 7 down to 0, MSB first within
// a byte. Items pass through a two-entry command queue, so push can run ahead of the
// renderer. A load is written as the idle renderer pops it; a draw first fetches the
// first glyph bytes from the single-read-port store, then produces one beat per
// cycle while the output is not stalled and later bytes are prefetched. Colors and
// scale are sampled while beats are produced, so write them only while the block is
// idle. The glyph store has no reset; draw only glyphs that have been loaded.
module scaled_glyph_pixel_expander #(
    parameter int GLYPH_COUNT = 96,
    parameter int FIRST_CODE  = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic        func,
    input  logic [7:0]  char_code,
    input  logic [2:0]  glyph_row,
    input  logic [7:0]  glyph_byte,
    input  logic [15:0] origin_x,
    input  logic [15:0] origin_y,
    output logic        empty,
    input  logic        pop,
    output logic [15:0] fill_x,
    output logic [15:0] fill_y,
    output logic [4:0]  fill_size,
    output logic [15:0] fill_color,
    output logic        last_dot,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    import sgpe_pkg::*;

    localparam int STORE_DEPTH = GLYPH_COUNT * 8;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);

    cfg_t              cfg;
    logic [15:0]       background_reg;
    logic [15:0]       foreground_reg;
    logic [4:0]        scale_reg;
    logic              cmd_valid;
    cmd_t              cmd;
    logic              cmd_pop;
    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [7:0]        ram_wdata;
    logic              ram_re;
    logic [ADDR_W-1:0] ram_raddr;
    logic [7:0]        ram_rdata;
    back_stat_t        stat;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            background_reg <= 16'h0000;
            foreground_reg <= 16'hFFFF;
            scale_reg      <= 5'd1;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_BACKGROUND: background_reg <= cfg_data;
                REG_FOREGROUND: foreground_reg <= cfg_data;
                REG_SCALE:      scale_reg      <= cfg_data[4:0];
                default:        ;
            endcase
        end
    end

    assign cfg.background = background_reg;
    assign cfg.foreground = foreground_reg;
    assign cfg.scale      = scale_reg;

    sgpe_ram #(
        .WIDTH (8),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    sgpe_front #(
        .GLYPH_COUNT (GLYPH_COUNT),
        .FIRST_CODE  (FIRST_CODE)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .func       (func),
        .char_code  (char_code),
        .glyph_row  (glyph_row),
        .glyph_byte (glyph_byte),
        .origin_x   (origin_x),
        .origin_y   (origin_y),
        .cmd_valid  (cmd_valid),
        .cmd        (cmd),
        .cmd_pop    (cmd_pop)
    );

    sgpe_back #(
        .ADDR_W (ADDR_W)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd_valid  (cmd_valid),
        .cmd        (cmd),
        .cmd_pop    (cmd_pop),
        .cfg        (cfg),
        .ram_we     (ram_we),
        .ram_waddr  (ram_waddr),
        .ram_wdata  (ram_wdata),
        .ram_re     (ram_re),
        .ram_raddr  (ram_raddr),
        .ram_rdata  (ram_rdata),
        .stat       (stat),
        .empty      (empty),
        .pop        (pop),
        .fill_x     (fill_x),
        .fill_y     (fill_y),
        .fill_size  (fill_size),
        .fill_color (fill_color),
        .last_dot   (last_dot)
    );

    // store writes never overlap a draw in progress
    a_no_write_while_drawing: assert property (
        @(posedge clk) disable iff (!rst_n)
        stat.ram_we |-> !stat.busy
    ) else $error("glyph store written during a draw");

    // a queued draw is only picked up by an idle renderer
    a_pop_only_idle: assert property (
        @(posedge clk) disable iff (!rst_n)
        cmd_pop |-> (!stat.busy && cmd_valid)
    ) else $error("command taken while renderer busy");

    // a waiting beat holds steady until it is taken
    a_beat_held: assert property (
        @(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty
            && $stable({fill_x, fill_y, fill_size, fill_color, last_dot}))
    ) else $error("waiting beat changed before pop");

endmodule
